// ----- hdl/ptqa_pkg.sv -----
// Package for the pooled task queue allocator: pool size, link and tag widths,
// operation and status codes.
// No dependencies.
package ptqa_pkg;

   // Pool size, fixed by the 4-bit handle and 3-bit slot fields
   localparam int SLOTS  = 8;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int TAG_W  = 64;

   // Link value that stands for null
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

   typedef logic [LINK_W-1:0] link_type;
   typedef logic [TAG_W-1:0]  tag_type;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_BUSY  = 3'd1,
      ST_FULL  = 3'd2,
      ST_NULL  = 3'd3,
      ST_EMPTY = 3'd4,
      ST_NOTQ  = 3'd5
   } status_type;

endpackage

// ----- hdl/pooled_task_queue_allocator_top.sv -----
// An accepted word passes through the request register, then the result register.
// Throughput: one word per cycle while the result side is not stalled.
// Each word reads and updates the link registers in one combinational pass.
// Reset (synchronous, active high) builds the free list 0..SLOTS-1 in order,
// empties the queue and clears both word valid flags; slot tags are not reset.
// Pooled task queue allocator: free-list stack plus doubly linked active queue.
// Depends on ptqa_pkg.
module pooled_task_queue_allocator_top
   import ptqa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [TAG_W-1:0] req_entry_tag,
   input  logic [3:0]       req_slot_handle,
   input  logic             req_printer_busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_slot_used,
   output logic [TAG_W-1:0] rsp_removed_tag,
   output logic [3:0]       rsp_queued_count
);

   // Request register
   logic             req_valid_ff;
   op_type           op_ff;
   tag_type          entry_tag_ff;
   logic [3:0]       handle_ff;
   logic             busy_ff;

   // Result register
   logic             rsp_valid_ff;
   status_type       status_ff;
   logic [2:0]       slot_used_ff;
   tag_type          removed_tag_ff;
   logic [3:0]       count_ff;

   // List state
   link_type         next_ff [SLOTS];
   link_type         prev_ff [SLOTS];
   logic [SLOTS-1:0] inq_ff;
   tag_type          tag_ff [SLOTS];
   link_type         free_head_ff;
   link_type         head_ff;
   link_type         tail_ff;
   logic [CNT_W-1:0] size_ff;

   // Next values
   link_type         next_in [SLOTS];
   link_type         prev_in [SLOTS];
   logic [SLOTS-1:0] inq_in;
   link_type         free_head_in;
   link_type         head_in;
   link_type         tail_in;
   logic [CNT_W-1:0] size_in;
   status_type       status_in;
   logic [IDX_W-1:0] slot_in;
   tag_type          removed_tag_in;
   logic             tag_we;
   logic [IDX_W-1:0] tag_idx;
   logic             advance;

   // Move the request word on when the result register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   // Request register: take a word whenever it is not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         op_ff        <= op_type'(req_operation);
         entry_tag_ff <= req_entry_tag;
         handle_ff    <= req_slot_handle;
         busy_ff      <= req_printer_busy;
      end
   end

   // Work out the status and the list update for the held request
   always_comb begin
      logic [IDX_W-1:0] s;
      logic [IDX_W-1:0] h;
      link_type         p;
      link_type         n;
      next_in        = next_ff;
      prev_in        = prev_ff;
      inq_in         = inq_ff;
      free_head_in   = free_head_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      size_in        = size_ff;
      status_in      = ST_OK;
      slot_in        = '0;
      removed_tag_in = '0;
      tag_we         = 1'b0;
      s              = free_head_ff[IDX_W-1:0];
      h              = handle_ff[IDX_W-1:0];
      tag_idx        = s;
      p              = prev_ff[h];
      n              = next_ff[h];
      unique case (op_ff)
         OP_ADD: begin
            priority if (busy_ff) begin
               status_in = ST_BUSY;
            end else if (free_head_ff >= NULL_LINK) begin
               status_in = ST_FULL;
            end else begin
               // pop free head, append at tail
               free_head_in = next_ff[s];
               tag_we       = 1'b1;
               next_in[s]   = NULL_LINK;
               prev_in[s]   = tail_ff;
               if (tail_ff < NULL_LINK) begin
                  next_in[tail_ff[IDX_W-1:0]] = LINK_W'(s);
               end else begin
                  head_in = LINK_W'(s);
               end
               tail_in   = LINK_W'(s);
               inq_in[s] = 1'b1;
               size_in   = size_ff + CNT_W'(1);
               slot_in   = s;
            end
         end
         OP_DELETE: begin
            tag_idx = h;
            priority if (handle_ff == 4'(NULL_LINK)) begin
               status_in = ST_NULL;
            end else if (head_ff >= NULL_LINK) begin
               status_in = ST_EMPTY;
            end else if (handle_ff >= 4'(NULL_LINK) || !inq_ff[h]) begin
               status_in = ST_NOTQ;
            end else begin
               // unlink, then push onto the free head
               if (p < NULL_LINK) begin
                  next_in[p[IDX_W-1:0]] = n;
               end else begin
                  head_in = n;
               end
               if (n < NULL_LINK) begin
                  prev_in[n[IDX_W-1:0]] = p;
               end else begin
                  tail_in = p;
               end
               prev_in[h] = NULL_LINK;
               next_in[h] = free_head_ff;
               if (free_head_ff < NULL_LINK) begin
                  prev_in[free_head_ff[IDX_W-1:0]] = LINK_W'(h);
               end
               free_head_in = LINK_W'(h);
               inq_in[h]    = 1'b0;
               if (size_ff != '0) begin
                  size_in = size_ff - CNT_W'(1);
               end
               slot_in        = h;
               removed_tag_in = tag_ff[h];
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // List state: commit the update as the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            next_ff[i] <= LINK_W'(i + 1);
            prev_ff[i] <= NULL_LINK;
         end
         inq_ff       <= '0;
         free_head_ff <= '0;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         size_ff      <= '0;
      end else if (advance) begin
         next_ff      <= next_in;
         prev_ff      <= prev_in;
         inq_ff       <= inq_in;
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         size_ff      <= size_in;
      end
   end

   // Tag store: written by a successful add
   always_ff @(posedge clock) begin
      if (advance && tag_we) begin
         tag_ff[tag_idx] <= entry_tag_ff;
      end
   end

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         status_ff      <= status_in;
         slot_used_ff   <= 3'(slot_in);
         removed_tag_ff <= removed_tag_in;
         count_ff       <= 4'(size_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_used    = slot_used_ff;
   assign rsp_removed_tag  = removed_tag_ff;
   assign rsp_queued_count = count_ff;

`ifndef SYNTHESIS
   // Queue size tracks the in-queue flags
   a_size_flags: assert property (@(posedge clock) disable iff (reset)
      $countones(inq_ff) == 32'(size_ff))
      else $error("queue size disagrees with in-queue flags");

   // Empty queue has a null head and tail
   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      (size_ff == '0) == (head_ff == NULL_LINK && tail_ff == NULL_LINK))
      else $error("queue head/tail disagree with size");

   // Refused requests report no slot and no tag
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_slot_used == '0 && rsp_removed_tag == '0))
      else $error("refused request carries a slot or tag");

   // A word moved on shows up as a result at the next edge
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced word lost");
`endif

endmodule

// ----- tb/tb_pooled_task_queue_allocator_top.sv -----
`timescale 1ns / 100ps
// Testbench for pooled_task_queue_allocator_top: directed words from a table, then random
// add/delete traffic checked against a behavioral model of the free list and active queue.
// Depends on ptqa_pkg and the allocator RTL.
module tb_pooled_task_queue_allocator_top;
   import ptqa_pkg::*;

   localparam int RANDOM_WORDS = 1900;
   localparam int QUIET_LIMIT  = 1000;
   localparam int ROWS         = 25;

   typedef struct packed {
      status_type status;
      logic [2:0] slot;
      tag_type    tag;
      logic [3:0] count;
   } report_type;

   typedef struct packed {
      op_type     op;
      tag_type    tag;
      logic [3:0] handle;
      logic       busy;
      logic       typed;
      report_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_operation = 1'b0;
   logic [TAG_W-1:0] req_entry_tag = '0;
   logic [3:0]       req_slot_handle = '0;
   logic             req_printer_busy = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_status;
   logic [2:0]       rsp_slot_used;
   logic [TAG_W-1:0] rsp_removed_tag;
   logic [3:0]       rsp_queued_count;

   // Model state of the pool
   link_type   link_next [SLOTS];
   link_type   link_prev [SLOTS];
   logic       slot_queued [SLOTS];
   tag_type    held_tag [SLOTS];
   link_type   free_top;
   link_type   queue_first;
   link_type   queue_last;
   logic [3:0] queue_len;

   report_type due_reports [$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         send_idle_pct = 24;
   int         rsp_idle_pct = 58;

   // Directed words; typed rows carry their result, the rest use the model
   stim_row_type directed_rows [ROWS] = '{
      '{OP_DELETE, 64'h0, NULL_LINK, 1'b0, 1'b1, '{ST_NULL, 3'd0, 64'h0, 4'd0}},
      '{OP_DELETE, 64'h0, 4'd0, 1'b0, 1'b1, '{ST_EMPTY, 3'd0, 64'h0, 4'd0}},
      '{OP_DELETE, '1, 4'd15, 1'b1, 1'b1, '{ST_EMPTY, 3'd0, 64'h0, 4'd0}},
      '{OP_ADD, '1, 4'd0, 1'b1, 1'b1, '{ST_BUSY, 3'd0, 64'h0, 4'd0}},
      '{OP_ADD, '1, 4'd15, 1'b0, 1'b1, '{ST_OK, 3'd0, 64'h0, 4'd1}},
      '{OP_ADD, 64'h0, 4'd0, 1'b0, 1'b1, '{ST_OK, 3'd1, 64'h0, 4'd2}},
      '{OP_DELETE, 64'h0, 4'd3, 1'b0, 1'b1, '{ST_NOTQ, 3'd0, 64'h0, 4'd2}},
      '{OP_DELETE, 64'h0, 4'd12, 1'b0, 1'b1, '{ST_NOTQ, 3'd0, 64'h0, 4'd2}},
      '{OP_ADD, 64'h0123_4567_89AB_CDEF, 4'd1, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'hFEDC_BA98_7654_3210, 4'd2, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 4'd4, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h8000_0000_0000_0001, 4'd9, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h7FFF_FFFF_FFFF_FFFE, 4'd7, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h1234, 4'd0, 1'b0, 1'b1, '{ST_FULL, 3'd0, 64'h0, 4'd8}},
      '{OP_ADD, 64'h5678, 4'd0, 1'b1, 1'b1, '{ST_BUSY, 3'd0, 64'h0, 4'd8}},
      '{OP_DELETE, 64'h0, 4'd7, 1'b1, 1'b0, '0},
      '{OP_DELETE, 64'h0, 4'd0, 1'b0, 1'b1, '{ST_OK, 3'd0, '1, 4'd6}},
      '{OP_DELETE, 64'h0, 4'd4, 1'b0, 1'b0, '0},
      '{OP_DELETE, 64'h0, 4'd4, 1'b0, 1'b1, '{ST_NOTQ, 3'd0, 64'h0, 4'd5}},
      '{OP_ADD, 64'h0000_0000_FFFF_FFFF, 4'd0, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'hFFFF_FFFF_0000_0000, 4'd0, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h1, 4'd0, 1'b0, 1'b0, '0},
      '{OP_ADD, 64'h2, 4'd0, 1'b0, 1'b1, '{ST_FULL, 3'd0, 64'h0, 4'd8}},
      '{OP_DELETE, 64'h0, 4'd1, 1'b0, 1'b1, '{ST_OK, 3'd1, 64'h0, 4'd7}}
   };

   pooled_task_queue_allocator_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_slot(link_type l);
      return l < SLOTS;
   endfunction

   // Apply one request to the model pool and return its report
   function automatic report_type allocate_or_release(op_type op, tag_type tag,
                                                      link_type handle, logic busy);
      report_type r;
      link_type   s, p, n;
      r = '0;
      r.status = ST_OK;
      if (op == OP_ADD) begin
         if (busy) begin
            r.status = ST_BUSY;
         end else if (!is_slot(free_top)) begin
            r.status = ST_FULL;
         end else begin
            // pop the free stack, append at the queue tail
            s = free_top;
            free_top = link_next[s];
            held_tag[s] = tag;
            link_next[s] = NULL_LINK;
            link_prev[s] = queue_last;
            if (is_slot(queue_last)) link_next[queue_last] = s;
            else queue_first = s;
            queue_last = s;
            slot_queued[s] = 1'b1;
            queue_len = queue_len + 1;
            r.slot = s[2:0];
         end
      end else if (handle == NULL_LINK) begin
         r.status = ST_NULL;
      end else if (!is_slot(queue_first)) begin
         r.status = ST_EMPTY;
      end else if (!is_slot(handle) || !slot_queued[handle]) begin
         r.status = ST_NOTQ;
      end else begin
         // unlink from the queue, push onto the free stack
         p = link_prev[handle];
         n = link_next[handle];
         if (is_slot(p)) link_next[p] = n;
         else queue_first = n;
         if (is_slot(n)) link_prev[n] = p;
         else queue_last = p;
         link_prev[handle] = NULL_LINK;
         link_next[handle] = free_top;
         if (is_slot(free_top)) link_prev[free_top] = handle;
         free_top = handle;
         slot_queued[handle] = 1'b0;
         if (queue_len != 0) queue_len = queue_len - 1;
         r.slot = handle[2:0];
         r.tag = held_tag[handle];
      end
      r.count = queue_len;
      return r;
   endfunction

   // Present one word, hold it until accepted, then record its report
   task automatic send_request(op_type op, tag_type tag, logic [3:0] handle, logic busy,
                               logic typed, report_type want);
      report_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_entry_tag    <= tag;
      req_slot_handle  <= handle;
      req_printer_busy <= busy;
      do @(posedge clock); while (req_stall);
      got = allocate_or_release(op, tag, handle, busy);
      due_reports.push_back(typed ? want : got);
   endtask

   // Mostly well-formed traffic: adds, and deletes of queued slots; some noise
   task automatic send_random_request(int add_pct);
      int         queued_slots [$];
      op_type     op;
      logic [3:0] handle;
      logic       busy;
      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DELETE;
      busy = ($urandom_range(0, 99) < 12);
      handle = 4'($urandom_range(0, 15));
      if (op == OP_DELETE) begin
         for (int i = 0; i < SLOTS; i++) if (slot_queued[i]) queued_slots.push_back(i);
         if (queued_slots.size() != 0 && $urandom_range(0, 99) < 80)
            handle = 4'(queued_slots[$urandom_range(0, queued_slots.size() - 1)]);
      end
      send_request(op, {$urandom, $urandom}, handle, busy, 1'b0, '0);
   endtask

   // Drop valid and hold off until every report has come back
   task automatic drain_reports();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_reports.size() != 0) @(posedge clock);
   endtask

   // Main sequence
   initial begin
      int add_pct;
      add_pct = 50;
      for (int i = 0; i < SLOTS; i++) begin
         link_next[i]   = (i + 1 < SLOTS) ? link_type'(i + 1) : NULL_LINK;
         link_prev[i]   = NULL_LINK;
         slot_queued[i] = 1'b0;
         held_tag[i]    = '0;
      end
      free_top    = '0;
      queue_first = NULL_LINK;
      queue_last  = NULL_LINK;
      queue_len   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROWS; r++)
         send_request(directed_rows[r].op, directed_rows[r].tag, directed_rows[r].handle,
                      directed_rows[r].busy, directed_rows[r].typed, directed_rows[r].want);
      drain_reports();

      for (int w = 0; w < RANDOM_WORDS; w++) begin
         // swap idle roles, then run with no idling
         if (w == RANDOM_WORDS / 3) begin
            drain_reports();
            send_idle_pct = 58;
            rsp_idle_pct  = 24;
         end
         if (w == 2 * RANDOM_WORDS / 3) begin
            drain_reports();
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         // sweep the queue between nearly empty and full
         if (w % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: add_pct = 15;
               1: add_pct = 50;
               default: add_pct = 85;
            endcase
         end
         send_random_request(add_pct);
      end

      drain_reports();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Random receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // Compare each accepted result word with the oldest expected report
   always @(posedge clock) begin : check_result
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            $display("%0t: unexpected result word: status %0d slot %0d tag %h count %0d",
                     $time, rsp_status, rsp_slot_used, rsp_removed_tag, rsp_queued_count);
            mismatch_count++;
         end else begin
            want = due_reports.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d", $time, want.status,
                        rsp_status);
               mismatch_count++;
            end
            if (rsp_slot_used !== want.slot) begin
               $display("%0t: slot_used expected %0d, actual %0d", $time, want.slot,
                        rsp_slot_used);
               mismatch_count++;
            end
            if (rsp_removed_tag !== want.tag) begin
               $display("%0t: removed_tag expected %h, actual %h", $time, want.tag,
                        rsp_removed_tag);
               mismatch_count++;
            end
            if (rsp_queued_count !== want.count) begin
               $display("%0t: queued_count expected %0d, actual %0d", $time, want.count,
                        rsp_queued_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
